FILE: design/desw_pkg.sv
// ----------------------------------------------------------------------------
// desw_pkg: shared types and constants for the edge swap unit
// Node and count widths, mode codes, controller states, cell structs and a
// population count helper.
// ----------------------------------------------------------------------------
package desw_pkg;

   localparam int MAX_NODES = 32;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int CFG_W     = 6;
   localparam int RANK_W    = 10;
   localparam int CNT_W     = 11;
   localparam int POP_W     = $clog2(MAX_NODES + 1);
   localparam int LVL_W     = $clog2(NODE_W + 1);

   localparam logic [CFG_W-1:0] NODE_COUNT_RESET = CFG_W'(MAX_NODES);

   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_SWAP  = 2'd2;

   typedef logic [MAX_NODES-1:0] row_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_FIND
   } state_type;

   // bit update for one cell: clear bits first, then set bits
   typedef struct packed {
      row_type clr;
      row_type set;
   } cell_wr_type;

   // what the active cell reports when a rank lands in its row
   typedef struct packed {
      logic              hit_first;
      logic              hit_second;
      logic [NODE_W-1:0] off_first;
      logic [NODE_W-1:0] off_second;
      row_type           row_first;
      row_type           row_second;
   } cell_hit_type;

   function automatic logic [POP_W-1:0] popcount(input row_type w);
      logic [POP_W-1:0] s;
      s = '0;
      for (int i = 0; i < MAX_NODES; i++) begin
         s = s + POP_W'(w[i]);
      end
      return s;
   endfunction

endpackage

FILE: design/desw_cell.sv
// ----------------------------------------------------------------------------
// desw_cell: one adjacency row of the chain
// Holds one row, applies bit updates, and while the scan token passes adds
// its masked edge count to the running prefix handed to the next cell.
// ----------------------------------------------------------------------------
module desw_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          row_live,
   input  desw_pkg::row_type             col_mask,
   input  desw_pkg::cell_wr_type         wr,
   input  logic [desw_pkg::RANK_W-1:0]   rank_first,
   input  logic [desw_pkg::RANK_W-1:0]   rank_second,
   input  logic                          token_in,
   input  logic [desw_pkg::CNT_W-1:0]    prefix_in,
   output logic                          token_out,
   output logic [desw_pkg::CNT_W-1:0]    prefix_out,
   output desw_pkg::row_type             row_out,
   output desw_pkg::cell_hit_type        hit
);
   import desw_pkg::*;

   row_type           row_ff, row_in;
   logic              token_ff;
   logic [CNT_W-1:0]  prefix_ff, prefix_in_nx;
   row_type           masked;
   logic [POP_W-1:0]  pop;
   logic [CNT_W-1:0]  upper;
   logic [CNT_W-1:0]  rk1, rk2;
   logic [CNT_W-1:0]  diff1, diff2;
   logic              in1, in2;

   assign row_in       = (row_ff & ~wr.clr) | wr.set;
   assign masked       = row_live ? (row_ff & col_mask) : '0;
   assign pop          = popcount(masked);
   assign upper        = prefix_in + CNT_W'(pop);
   assign prefix_in_nx = upper;

   assign rk1   = CNT_W'(rank_first);
   assign rk2   = CNT_W'(rank_second);
   assign diff1 = rk1 - prefix_in;
   assign diff2 = rk2 - prefix_in;
   assign in1   = token_in && (rk1 >= prefix_in) && (rk1 < upper);
   assign in2   = token_in && (rk2 >= prefix_in) && (rk2 < upper);

   always_comb begin
      hit.hit_first  = in1;
      hit.hit_second = in2;
      hit.off_first  = in1 ? diff1[NODE_W-1:0] : '0;
      hit.off_second = in2 ? diff2[NODE_W-1:0] : '0;
      hit.row_first  = in1 ? masked : '0;
      hit.row_second = in2 ? masked : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         token_ff <= 1'b0;
      end else begin
         row_ff   <= row_in;
         token_ff <= token_in;
      end
   end

   always_ff @(posedge clock) begin
      prefix_ff <= prefix_in_nx;
   end

   assign token_out  = token_ff;
   assign prefix_out = prefix_ff;
   assign row_out    = row_ff;

endmodule

FILE: design/desw_select.sv
// ----------------------------------------------------------------------------
// desw_select: k-th set bit finder
// Binary search over halves of a row word, one level per cycle, giving the
// column of the set bit with the given rank inside the row.
// ----------------------------------------------------------------------------
module desw_select (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  desw_pkg::row_type             word,
   input  logic [desw_pkg::NODE_W-1:0]   rank,
   output logic                          done,
   output logic [desw_pkg::NODE_W-1:0]   col
);
   import desw_pkg::*;

   row_type            w_ff, w_in;
   logic [NODE_W-1:0]  k_ff, k_in;
   logic [NODE_W-1:0]  col_ff, col_in;
   logic [LVL_W-1:0]   lvl_ff, lvl_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [NODE_W-1:0]  half;
   row_type            low_mask;
   logic [POP_W-1:0]   low_pop;
   logic               go_low;

   assign half     = NODE_W'((MAX_NODES / 2) >> lvl_ff);
   assign low_mask = ~({MAX_NODES{1'b1}} << half);
   assign low_pop  = popcount(w_ff & low_mask);
   assign go_low   = POP_W'(k_ff) < low_pop;

   always_comb begin
      w_in    = w_ff;
      k_in    = k_ff;
      col_in  = col_ff;
      lvl_in  = lvl_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         w_in   = word;
         k_in   = rank;
         col_in = '0;
         lvl_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (go_low) begin
            w_in = w_ff & low_mask;
         end else begin
            w_in   = w_ff >> half;
            k_in   = k_ff - NODE_W'(low_pop);
            col_in = col_ff | half;
         end
         lvl_in = lvl_ff + 1'b1;
         if (lvl_ff == LVL_W'(NODE_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         lvl_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         lvl_ff  <= lvl_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff   <= w_in;
      k_ff   <= k_in;
      col_ff <= col_in;
   end

   assign done = done_ff;
   assign col  = col_ff;

endmodule

FILE: design/degree_preserving_edge_swap_unit.sv
// ----------------------------------------------------------------------------
// degree_preserving_edge_swap_unit: directed adjacency matrix with edge swap
// Row cells hold the matrix; a scan token walks the chain to rank edges.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken on start while busy is low. Write (mode 0) sets
//   or clears one bit and updates the edge total; read (mode 1) returns one
//   bit; swap (mode 2) locates the edges of ranks rank_first and
//   rank_second in row-major order and swaps their targets when legal.
//   Every command gives one result beat on the rsp_ ports, marked by
//   rsp_valid for one cycle; the receiver cannot stall it.
//   Read, write and unknown modes answer one cycle after acceptance and
//   keep busy low, so one can be taken every cycle.
//   A swap keeps busy high until its result beat: the scan token visits
//   each of the MAX_NODES row cells once, one per cycle, then two select
//   units, one per edge, locate each edge inside its row by a binary
//   search over the column index bits. A rank error answers after the scan.
//   csr_we writes node_count (scan square size) and is meant for idle time.
//   Reset clears the matrix and the edge total, sets node_count to 32.
// ----------------------------------------------------------------------------
module degree_preserving_edge_swap_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_mode,
   input  logic [desw_pkg::NODE_W-1:0]   req_row,
   input  logic [desw_pkg::NODE_W-1:0]   req_col,
   input  logic                          req_bit_value,
   input  logic [desw_pkg::RANK_W-1:0]   req_rank_first,
   input  logic [desw_pkg::RANK_W-1:0]   req_rank_second,
   input  logic                          csr_we,
   input  logic [desw_pkg::CFG_W-1:0]    csr_wdata,
   output logic                          rsp_valid,
   output logic                          rsp_bit_out,
   output logic                          rsp_accepted,
   output logic                          rsp_rank_error,
   output logic [desw_pkg::CNT_W-1:0]    rsp_edge_total,
   output logic [desw_pkg::NODE_W-1:0]   rsp_first_source,
   output logic [desw_pkg::NODE_W-1:0]   rsp_first_target,
   output logic [desw_pkg::NODE_W-1:0]   rsp_second_source,
   output logic [desw_pkg::NODE_W-1:0]   rsp_second_target
);
   import desw_pkg::*;

   state_type          state_ff, state_in;
   logic [NODE_W-1:0]  step_ff, step_in;
   logic [CFG_W-1:0]   nodes_ff, nodes_in;
   logic [CNT_W-1:0]   edge_ff, edge_in;
   logic [RANK_W-1:0]  rank1_ff, rank1_in, rank2_ff, rank2_in;

   logic               found1_ff, found1_in, found2_ff, found2_in;
   logic [NODE_W-1:0]  a_ff, a_in, b_ff, b_in;
   logic [NODE_W-1:0]  k1_ff, k1_in, k2_ff, k2_in;
   row_type            w1_ff, w1_in, w2_ff, w2_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               bit_ff, bit_in, acc_ff, acc_in, err_ff, err_in;
   logic [CNT_W-1:0]   tot_ff, tot_in;
   logic [NODE_W-1:0]  fs_ff, fs_in, ft_ff, ft_in, ss_ff, ss_in, st_ff, st_in;

   logic               accept;
   logic               scan_token;
   logic               sel_start;
   logic               sel1_done, sel2_done;
   logic               sel_done;
   logic [NODE_W-1:0]  c_col, d_col;
   logic               swap_ok;
   logic               do_swap;
   logic               rd_bit;

   logic [CFG_W-1:0]   scan_n;
   row_type            col_mask;
   row_type            row_q [MAX_NODES];
   cell_wr_type        cell_wr [MAX_NODES];
   cell_hit_type       cell_hit [MAX_NODES];
   cell_hit_type       hit_any;
   logic               tok [MAX_NODES+1];
   logic [CNT_W-1:0]   pre [MAX_NODES+1];

   assign accept = start && (state_ff == ST_IDLE);
   assign scan_n = (nodes_ff > CFG_W'(MAX_NODES)) ? CFG_W'(MAX_NODES) : nodes_ff;

   always_comb begin
      for (int j = 0; j < MAX_NODES; j++) begin
         col_mask[j] = (CFG_W'(j) < scan_n);
      end
   end

   assign tok[0] = scan_token;
   assign pre[0] = '0;

   for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
      desw_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .row_live    (CFG_W'(i) < scan_n),
         .col_mask    (col_mask),
         .wr          (cell_wr[i]),
         .rank_first  (rank1_ff),
         .rank_second (rank2_ff),
         .token_in    (tok[i]),
         .prefix_in   (pre[i]),
         .token_out   (tok[i+1]),
         .prefix_out  (pre[i+1]),
         .row_out     (row_q[i]),
         .hit         (cell_hit[i])
      );
   end

   // only the cell holding the token reports, so an OR picks its beat
   always_comb begin
      hit_any = '0;
      for (int i = 0; i < MAX_NODES; i++) begin
         hit_any = hit_any | cell_hit[i];
      end
   end

   desw_select u_sel_first (
      .clock (clock),
      .reset (reset),
      .start (sel_start),
      .word  (w1_ff),
      .rank  (k1_ff),
      .done  (sel1_done),
      .col   (c_col)
   );

   desw_select u_sel_second (
      .clock (clock),
      .reset (reset),
      .start (sel_start),
      .word  (w2_ff),
      .rank  (k2_ff),
      .done  (sel2_done),
      .col   (d_col)
   );

   // both selects start together and take the same number of cycles
   assign sel_done = sel1_done && sel2_done;

   assign rd_bit  = row_q[req_row][req_col];
   // w1/w2 are masked rows, fine here since c and d lie inside the square
   assign swap_ok = (a_ff != b_ff) && (c_col != d_col) && (a_ff != d_col) &&
                    (c_col != b_ff) && !w1_ff[d_col] && !w2_ff[c_col];
   assign do_swap = (state_ff == ST_FIND) && sel_done && swap_ok;

   always_comb begin
      for (int i = 0; i < MAX_NODES; i++) begin
         cell_wr[i] = '0;
         if (accept && req_mode == MODE_WRITE && req_row == NODE_W'(i)) begin
            cell_wr[i].clr = row_type'(1) << req_col;
            cell_wr[i].set = row_type'(req_bit_value) << req_col;
         end
         if (do_swap) begin
            if (a_ff == NODE_W'(i)) begin
               cell_wr[i].clr = row_type'(1) << c_col;
               cell_wr[i].set = row_type'(1) << d_col;
            end
            if (b_ff == NODE_W'(i)) begin
               cell_wr[i].clr = row_type'(1) << d_col;
               cell_wr[i].set = row_type'(1) << c_col;
            end
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_mode == MODE_SWAP) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (step_ff == NODE_W'(MAX_NODES - 1)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = (found1_ff && found2_ff) ? ST_FIND : ST_IDLE;
         end
         ST_FIND: begin
            if (sel_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // controller outputs and response beat
   always_comb begin
      busy         = (state_ff != ST_IDLE);
      scan_token   = (state_ff == ST_SCAN) && (step_ff == '0);
      sel_start    = (state_ff == ST_CHECK) && found1_ff && found2_ff;
      rsp_valid_in = 1'b0;
      bit_in       = 1'b0;
      acc_in       = 1'b0;
      err_in       = 1'b0;
      tot_in       = edge_in;
      fs_in        = '0;
      ft_in        = '0;
      ss_in        = '0;
      st_in        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_mode != MODE_SWAP) begin
               rsp_valid_in = 1'b1;
               bit_in       = (req_mode == MODE_READ) && rd_bit;
            end
         end
         ST_CHECK: begin
            if (!(found1_ff && found2_ff)) begin
               rsp_valid_in = 1'b1;
               err_in       = 1'b1;
            end
         end
         ST_FIND: begin
            if (sel_done) begin
               rsp_valid_in = 1'b1;
               acc_in       = swap_ok;
               fs_in        = a_ff;
               ft_in        = c_col;
               ss_in        = b_ff;
               st_in        = d_col;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      nodes_in  = csr_we ? csr_wdata : nodes_ff;
      edge_in   = edge_ff;
      step_in   = (state_ff == ST_SCAN) ? step_ff + 1'b1 : '0;
      rank1_in  = rank1_ff;
      rank2_in  = rank2_ff;
      found1_in = found1_ff;
      found2_in = found2_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      k1_in     = k1_ff;
      k2_in     = k2_ff;
      w1_in     = w1_ff;
      w2_in     = w2_ff;
      if (accept) begin
         found1_in = 1'b0;
         found2_in = 1'b0;
         rank1_in  = req_rank_first;
         rank2_in  = req_rank_second;
         if (req_mode == MODE_WRITE) begin
            if (rd_bit && !req_bit_value) begin
               edge_in = edge_ff - 1'b1;
            end else if (!rd_bit && req_bit_value) begin
               edge_in = edge_ff + 1'b1;
            end
         end
      end
      if (state_ff == ST_SCAN) begin
         if (hit_any.hit_first) begin
            found1_in = 1'b1;
            a_in      = step_ff;
            k1_in     = hit_any.off_first;
            w1_in     = hit_any.row_first;
         end
         if (hit_any.hit_second) begin
            found2_in = 1'b1;
            b_in      = step_ff;
            k2_in     = hit_any.off_second;
            w2_in     = hit_any.row_second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         nodes_ff     <= NODE_COUNT_RESET;
         edge_ff      <= '0;
         found1_ff    <= 1'b0;
         found2_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         nodes_ff     <= nodes_in;
         edge_ff      <= edge_in;
         found1_ff    <= found1_in;
         found2_ff    <= found2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rank1_ff <= rank1_in;
      rank2_ff <= rank2_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      k1_ff    <= k1_in;
      k2_ff    <= k2_in;
      w1_ff    <= w1_in;
      w2_ff    <= w2_in;
      bit_ff   <= bit_in;
      acc_ff   <= acc_in;
      err_ff   <= err_in;
      tot_ff   <= tot_in;
      fs_ff    <= fs_in;
      ft_ff    <= ft_in;
      ss_ff    <= ss_in;
      st_ff    <= st_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bit_out       = bit_ff;
   assign rsp_accepted      = acc_ff;
   assign rsp_rank_error    = err_ff;
   assign rsp_edge_total    = tot_ff;
   assign rsp_first_source  = fs_ff;
   assign rsp_first_target  = ft_ff;
   assign rsp_second_source = ss_ff;
   assign rsp_second_target = st_ff;

endmodule

FILE: design/desw_checker.sv
// ----------------------------------------------------------------------------
// desw_checker: port-level checks for the edge swap unit
// Watches the command and result ports; bound to the top level below.
// ----------------------------------------------------------------------------
module desw_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [1:0]                    req_mode,
   input  logic                          rsp_valid,
   input  logic                          rsp_bit_out,
   input  logic                          rsp_accepted,
   input  logic                          rsp_rank_error,
   input  logic [desw_pkg::NODE_W-1:0]   rsp_first_source,
   input  logic [desw_pkg::NODE_W-1:0]   rsp_first_target,
   input  logic [desw_pkg::NODE_W-1:0]   rsp_second_source,
   input  logic [desw_pkg::NODE_W-1:0]   rsp_second_target
);
   import desw_pkg::*;

   // an accepted swap command must raise busy
   a_swap_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode == MODE_SWAP) |=> busy)
      else $error("swap beat did not raise busy");

   a_acc_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_accepted && rsp_rank_error))
      else $error("accepted and rank_error together");

   a_err_nodes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rank_error) |->
         (rsp_first_source == '0 && rsp_first_target == '0 &&
          rsp_second_source == '0 && rsp_second_target == '0))
      else $error("node fields set on rank error");

   a_acc_distinct: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accepted) |->
         (rsp_first_source != rsp_second_source &&
          rsp_first_target != rsp_second_target &&
          rsp_first_source != rsp_second_target &&
          rsp_first_target != rsp_second_source))
      else $error("swap performed on nodes that are not distinct");

   a_bit_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bit_out) |-> (!rsp_accepted && !rsp_rank_error))
      else $error("read bit set on a swap result");

endmodule

bind degree_preserving_edge_swap_unit desw_checker u_desw_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_mode          (req_mode),
   .rsp_valid         (rsp_valid),
   .rsp_bit_out       (rsp_bit_out),
   .rsp_accepted      (rsp_accepted),
   .rsp_rank_error    (rsp_rank_error),
   .rsp_first_source  (rsp_first_source),
   .rsp_first_target  (rsp_first_target),
   .rsp_second_source (rsp_second_source),
   .rsp_second_target (rsp_second_target)
);

FILE: verif/edge_swap_checker.sv
// ----------------------------------------------------------------------------
// edge_swap_checker: result predictor and comparator for the edge swap unit
// Watches command and result beats, keeps its own adjacency matrix, edge
// total and node count, and compares each result beat field by field with
// the oldest predicted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edge_swap_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [1:0]                    req_mode,
   input  logic [desw_pkg::NODE_W-1:0]   req_row,
   input  logic [desw_pkg::NODE_W-1:0]   req_col,
   input  logic                          req_bit_value,
   input  logic [desw_pkg::RANK_W-1:0]   req_rank_first,
   input  logic [desw_pkg::RANK_W-1:0]   req_rank_second,
   input  logic                          csr_we,
   input  logic [desw_pkg::CFG_W-1:0]    csr_wdata,
   input  logic                          rsp_valid,
   input  logic                          rsp_bit_out,
   input  logic                          rsp_accepted,
   input  logic                          rsp_rank_error,
   input  logic [desw_pkg::CNT_W-1:0]    rsp_edge_total,
   input  logic [desw_pkg::NODE_W-1:0]   rsp_first_source,
   input  logic [desw_pkg::NODE_W-1:0]   rsp_first_target,
   input  logic [desw_pkg::NODE_W-1:0]   rsp_second_source,
   input  logic [desw_pkg::NODE_W-1:0]   rsp_second_target,
   output int                            fail_count,
   output int                            outstanding
);
   import desw_pkg::*;

   typedef struct packed {
      logic              bit_out;
      logic              accepted;
      logic              rank_error;
      logic [CNT_W-1:0]  edge_total;
      logic [NODE_W-1:0] first_source;
      logic [NODE_W-1:0] first_target;
      logic [NODE_W-1:0] second_source;
      logic [NODE_W-1:0] second_target;
   } cmd_result_type;

   row_type           adj_rows [MAX_NODES];
   logic [CNT_W-1:0]  edge_total_q;
   logic [CFG_W-1:0]  node_count_q;
   cmd_result_type    expected_results [$];
   int                mismatch_total = 0;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // walk the scanned square in row-major order, counting set bits
   function automatic bit find_ranked_edge(input int rank, output int src, output int dst);
      int span;
      int seen;
      span = (node_count_q > MAX_NODES) ? MAX_NODES : int'(node_count_q);
      seen = 0;
      src  = 0;
      dst  = 0;
      if (rank >= int'(edge_total_q)) return 1'b0;
      for (int i = 0; i < span; i++) begin
         for (int j = 0; j < span; j++) begin
            if (adj_rows[i][j]) begin
               if (seen == rank) begin
                  src = i;
                  dst = j;
                  return 1'b1;
               end
               seen++;
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic cmd_result_type predict_command(
      input logic [1:0]        mode,
      input logic [NODE_W-1:0] row,
      input logic [NODE_W-1:0] col,
      input logic              bitv,
      input logic [RANK_W-1:0] rank_a,
      input logic [RANK_W-1:0] rank_b
   );
      cmd_result_type res;
      int             src1, dst1, src2, dst2;
      bit             found;
      res = '0;
      case (mode)
         MODE_WRITE: begin
            if (adj_rows[row][col] && !bitv) edge_total_q = edge_total_q - 1'b1;
            else if (!adj_rows[row][col] && bitv) edge_total_q = edge_total_q + 1'b1;
            adj_rows[row][col] = bitv;
         end
         MODE_READ: begin
            res.bit_out = adj_rows[row][col];
         end
         MODE_SWAP: begin
            found = find_ranked_edge(int'(rank_a), src1, dst1);
            if (found) found = find_ranked_edge(int'(rank_b), src2, dst2);
            if (!found) begin
               res.rank_error = 1'b1;
            end else begin
               res.first_source  = NODE_W'(src1);
               res.first_target  = NODE_W'(dst1);
               res.second_source = NODE_W'(src2);
               res.second_target = NODE_W'(dst2);
               if (src1 != src2 && dst1 != dst2 && src1 != dst2 && dst1 != src2 &&
                   !adj_rows[src1][dst2] && !adj_rows[src2][dst1]) begin
                  adj_rows[src1][dst1] = 1'b0;
                  adj_rows[src2][dst2] = 1'b0;
                  adj_rows[src1][dst2] = 1'b1;
                  adj_rows[src2][dst1] = 1'b1;
                  res.accepted = 1'b1;
               end
            end
         end
         default: ;
      endcase
      res.edge_total = edge_total_q;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_total++;
      end
   endtask

   always @(posedge clock) begin
      cmd_result_type want;
      if (reset) begin
         foreach (adj_rows[i]) adj_rows[i] = '0;
         edge_total_q = '0;
         node_count_q = NODE_COUNT_RESET;
         expected_results.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               $error("result beat with no command outstanding");
               mismatch_total++;
            end else begin
               want = expected_results.pop_front();
               check_field("bit_out", 32'(want.bit_out), 32'(rsp_bit_out));
               check_field("accepted", 32'(want.accepted), 32'(rsp_accepted));
               check_field("rank_error", 32'(want.rank_error), 32'(rsp_rank_error));
               check_field("edge_total", 32'(want.edge_total), 32'(rsp_edge_total));
               check_field("first_source", 32'(want.first_source),
                           32'(rsp_first_source));
               check_field("first_target", 32'(want.first_target),
                           32'(rsp_first_target));
               check_field("second_source", 32'(want.second_source),
                           32'(rsp_second_source));
               check_field("second_target", 32'(want.second_target),
                           32'(rsp_second_target));
            end
         end
         if (csr_we) node_count_q = csr_wdata;
         if (start && !busy) begin
            expected_results.push_back(predict_command(req_mode, req_row, req_col,
               req_bit_value, req_rank_first, req_rank_second));
         end
      end
      outstanding <= expected_results.size();
      fail_count  <= mismatch_total;
   end

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: regression bench for degree_preserving_edge_swap_unit
// Directed writes, reads and swaps around the matrix corners and the swap
// corner cases, then random command streams under several node counts with
// random gaps; results are checked by edge_swap_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import desw_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 45;
   localparam int PHASE_ITEMS   = 55;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [1:0]        req_mode;
   logic [NODE_W-1:0] req_row;
   logic [NODE_W-1:0] req_col;
   logic              req_bit_value;
   logic [RANK_W-1:0] req_rank_first;
   logic [RANK_W-1:0] req_rank_second;
   logic              csr_we;
   logic [CFG_W-1:0]  csr_wdata;
   logic              rsp_valid;
   logic              rsp_bit_out;
   logic              rsp_accepted;
   logic              rsp_rank_error;
   logic [CNT_W-1:0]  rsp_edge_total;
   logic [NODE_W-1:0] rsp_first_source;
   logic [NODE_W-1:0] rsp_first_target;
   logic [NODE_W-1:0] rsp_second_source;
   logic [NODE_W-1:0] rsp_second_target;

   int                fail_count;
   int                outstanding;
   int                cycle_count = 0;
   int                nodes_in_use = 32;
   logic [CNT_W-1:0]  seen_total = '0;
   int                phase_nodes [7] = '{4, 1, 0, 63, 32, 9, 32};

   degree_preserving_edge_swap_unit uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_row           (req_row),
      .req_col           (req_col),
      .req_bit_value     (req_bit_value),
      .req_rank_first    (req_rank_first),
      .req_rank_second   (req_rank_second),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_bit_out       (rsp_bit_out),
      .rsp_accepted      (rsp_accepted),
      .rsp_rank_error    (rsp_rank_error),
      .rsp_edge_total    (rsp_edge_total),
      .rsp_first_source  (rsp_first_source),
      .rsp_first_target  (rsp_first_target),
      .rsp_second_source (rsp_second_source),
      .rsp_second_target (rsp_second_target)
   );

   edge_swap_checker swap_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_row           (req_row),
      .req_col           (req_col),
      .req_bit_value     (req_bit_value),
      .req_rank_first    (req_rank_first),
      .req_rank_second   (req_rank_second),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_bit_out       (rsp_bit_out),
      .rsp_accepted      (rsp_accepted),
      .rsp_rank_error    (rsp_rank_error),
      .rsp_edge_total    (rsp_edge_total),
      .rsp_first_source  (rsp_first_source),
      .rsp_first_target  (rsp_first_target),
      .rsp_second_source (rsp_second_source),
      .rsp_second_target (rsp_second_target),
      .fail_count        (fail_count),
      .outstanding       (outstanding)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("degree_preserving_edge_swap_unit regression: fail");
         $finish;
      end
   end

   // latest edge total seen, used to aim swap ranks at real edges
   always @(posedge clock) begin
      if (rsp_valid) seen_total <= rsp_edge_total;
   end

   // start stays high on return so back-to-back beats need no gap
   task automatic issue(input logic [1:0] mode, input int row, input int col,
                        input logic bitv, input int rank_a, input int rank_b);
      @(negedge clock);
      start           <= 1'b1;
      req_mode        <= mode;
      req_row         <= NODE_W'(row);
      req_col         <= NODE_W'(col);
      req_bit_value   <= bitv;
      req_rank_first  <= RANK_W'(rank_a);
      req_rank_second <= RANK_W'(rank_b);
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (cycles - 1) @(posedge clock);
      end
   endtask

   task automatic random_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) hold_off(0);
      else if (pick < 92) hold_off($urandom_range(1, 3));
      else hold_off($urandom_range(8, 45));
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_node_count(input int value);
      drain();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= CFG_W'(value);
      @(negedge clock);
      csr_we    <= 1'b0;
      nodes_in_use = value;
   endtask

   function automatic int pick_node(input int span);
      if ($urandom_range(0, 99) < 85) return $urandom_range(0, span - 1);
      return $urandom_range(0, 31);
   endfunction

   function automatic int pick_rank();
      if (seen_total != 0 && $urandom_range(0, 9) != 0)
         return $urandom_range(0, int'(seen_total) - 1);
      return $urandom_range(0, 1023);
   endfunction

   task automatic random_command();
      int span;
      int pick;
      span = (nodes_in_use == 0) ? 1 : ((nodes_in_use > 32) ? 32 : nodes_in_use);
      pick = $urandom_range(0, 99);
      if (pick < 30)
         issue(MODE_WRITE, pick_node(span), pick_node(span), $urandom_range(0, 99) < 65,
               $urandom_range(0, 1023), $urandom_range(0, 1023));
      else if (pick < 40)
         issue(MODE_READ, pick_node(span), pick_node(span), 1'($urandom_range(0, 1)),
               $urandom_range(0, 1023), $urandom_range(0, 1023));
      else if (pick < 95)
         issue(MODE_SWAP, $urandom_range(0, 31), $urandom_range(0, 31),
               1'($urandom_range(0, 1)), pick_rank(), pick_rank());
      else
         issue(MODE_UNUSED, $urandom_range(0, 31), $urandom_range(0, 31),
               1'($urandom_range(0, 1)), $urandom_range(0, 1023),
               $urandom_range(0, 1023));
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_mode        = MODE_WRITE;
      req_row         = '0;
      req_col         = '0;
      req_bit_value   = 1'b0;
      req_rank_first  = '0;
      req_rank_second = '0;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: corners, duplicate writes, legal and illegal swaps
      issue(MODE_READ, 0, 0, 1'b0, 0, 0);
      issue(MODE_WRITE, 0, 1, 1'b1, 0, 0);
      issue(MODE_WRITE, 2, 3, 1'b1, 0, 0);
      issue(MODE_WRITE, 2, 3, 1'b1, 0, 0);
      issue(MODE_WRITE, 5, 5, 1'b0, 0, 0);
      random_gap();
      issue(MODE_READ, 0, 1, 1'b0, 0, 0);
      issue(MODE_SWAP, 0, 0, 1'b0, 0, 1);
      issue(MODE_SWAP, 0, 0, 1'b0, 0, 0);
      issue(MODE_SWAP, 0, 0, 1'b0, 2, 0);
      issue(MODE_SWAP, 31, 31, 1'b1, 1023, 1023);
      issue(MODE_WRITE, 31, 31, 1'b1, 1023, 0);
      issue(MODE_WRITE, 31, 0, 1'b1, 0, 1023);
      issue(MODE_WRITE, 0, 31, 1'b1, 0, 0);
      random_gap();
      issue(MODE_READ, 31, 31, 1'b0, 0, 0);
      issue(MODE_SWAP, 0, 0, 1'b0, 0, 1);
      issue(MODE_SWAP, 0, 0, 1'b0, 2, 3);
      issue(MODE_WRITE, 0, 1, 1'b1, 0, 0);
      // source of the lower-ranked edge already points at the higher-ranked edge's target
      issue(MODE_SWAP, 0, 0, 1'b0, 1, 4);
      issue(MODE_UNUSED, 31, 31, 1'b1, 1023, 1023);
      issue(MODE_WRITE, 31, 31, 1'b0, 0, 0);
      issue(MODE_READ, 31, 0, 1'b0, 0, 0);
      issue(MODE_SWAP, 0, 0, 1'b0, 0, 1023);

      set_node_count(32);
      foreach (phase_nodes[p]) begin
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            random_command();
            // sender waits out every result once mid-stream
            if (p == 0 && k == PHASE_ITEMS / 2) drain();
            else if (k % 9 < 4) random_gap();
         end
         set_node_count(phase_nodes[p]);
      end
      for (int k = 0; k < 15; k++) begin
         random_command();
         random_gap();
      end

      drain();
      if (fail_count == 0 && outstanding == 0) begin
         $display("degree_preserving_edge_swap_unit regression: pass");
      end else begin
         $display("degree_preserving_edge_swap_unit regression: fail");
      end
      $finish;
   end

endmodule

FILE: degree_preserving_edge_swap_unit.f
design/desw_pkg.sv
design/desw_cell.sv
design/desw_select.sv
design/degree_preserving_edge_swap_unit.sv
design/desw_checker.sv
verif/edge_swap_checker.sv
verif/tb.sv
